[rtl/aptp_pkg.sv]
`timescale 1ns / 1ps
package aptp_pkg;
   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_SETPRI = 2'd2,
      REQ_PICK   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_IGNORED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_AGE,
      BK_DONE
   } back_state_type;

   localparam logic signed [5:0] PRIO_MAX  = 6'sd20;
   localparam logic signed [5:0] PRIO_MIN  = -6'sd20;
   localparam logic signed [7:0] DYN_FLOOR = -8'sd128;

   // classified command handed from front to back
   typedef struct packed {
      req_kind_type kind;
      logic         slot_ok;
      logic [5:0]   slot;
      logic         prio_ok;
      logic signed [5:0] prio;
   } cmd_type;
endpackage

[rtl/aging_priority_task_picker.sv]
`timescale 1ns / 1ps
// Ready-task picker with priority aging. A two-entry command queue accepts and
// classifies words; the back end runs one command at a time. Insert, remove and
// set-priority are carried out in the done state; a pick on a non-empty set
// then scans the slots to select (one slot per cycle) and ages them (one per
// cycle), done by the single slot-sequential compare/age unit. The back end
// accepts a new command only when idle and the last result has been taken.
// The result register holds one word; the back end waits while it is not taken.
module aging_priority_task_picker #(
   parameter int TASK_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // req_type[1:0], task_id[5:2], new_prio[11:6]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // chosen_id[3:0], chosen_valid[4], status[6:5]
);
   logic [2:0]        step_ff;
   logic              q_valid, q_ready;
   aptp_pkg::cmd_type q_cmd;
   logic [3:0]        oid;
   logic              ohit;
   logic [1:0]        ost;

   always_ff @(posedge clock) begin
      if (reset) step_ff <= 3'd1;
      else if (csr_wr_en) step_ff <= csr_wr_data;
   end

   aptp_front #(.TASK_SLOTS(TASK_SLOTS)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_type(req_tdata[1:0]), .in_id(req_tdata[5:2]),
      .in_prio(req_tdata[11:6]),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
   );

   aptp_back #(.TASK_SLOTS(TASK_SLOTS)) u_back (
      .clock(clock), .reset(reset), .aging_step(step_ff),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_id(oid), .out_hit(ohit), .out_status(ost)
   );

   assign rsp_tdata = {1'b0, ost, ohit, oid};
endmodule

[rtl/aptp_front.sv]
`timescale 1ns / 1ps
module aptp_front #(
   parameter int TASK_SLOTS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [1:0]           in_type,
   input  logic [3:0]           in_id,
   input  logic signed [5:0]    in_prio,
   output logic                 q_valid,
   input  logic                 q_ready,
   output aptp_pkg::cmd_type    q_cmd
);
   localparam int DEPTH = 2;
   aptp_pkg::cmd_type buf_ff [DEPTH];
   logic              wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]        cnt_ff, cnt_in;
   aptp_pkg::cmd_type cmd;
   logic              push, pop;

   always_comb begin
      cmd.kind    = aptp_pkg::req_kind_type'(in_type);
      cmd.slot_ok = ({3'b0, in_id} < 7'(TASK_SLOTS));
      cmd.slot    = {2'b0, in_id};
      cmd.prio_ok = (in_prio <= aptp_pkg::PRIO_MAX) && (in_prio >= aptp_pkg::PRIO_MIN);
      cmd.prio    = in_prio;
   end

   assign in_ready = (cnt_ff != 2'(DEPTH));
   assign push     = in_valid && in_ready;
   assign q_valid  = (cnt_ff != 2'd0);
   assign pop      = q_valid && q_ready;
   assign q_cmd    = buf_ff[rp_ff];
   assign wp_in    = push ? ~wp_ff : wp_ff;
   assign rp_in    = pop ? ~rp_ff : rp_ff;
   assign cnt_in   = cnt_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) buf_ff[wp_ff] <= cmd;
   end
endmodule

[rtl/aptp_back.sv]
`timescale 1ns / 1ps
module aptp_back #(
   parameter int TASK_SLOTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [2:0]        aging_step,
   input  logic              q_valid,
   output logic              q_ready,
   input  aptp_pkg::cmd_type q_cmd,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [3:0]        out_id,
   output logic              out_hit,
   output logic [1:0]        out_status
);
   localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CW = $clog2(TASK_SLOTS + 1);

   logic [TASK_SLOTS-1:0] rdy_ff, rdy_in;
   logic signed [5:0] sp_ff [TASK_SLOTS];
   logic signed [7:0] dp_ff [TASK_SLOTS];
   logic [IW-1:0]     rk_ff [TASK_SLOTS];
   logic [CW-1:0]     cnt_ff;

   aptp_pkg::back_state_type st_ff, st_in;
   aptp_pkg::cmd_type        cmd_ff;
   logic [IW-1:0] idx_ff, idx_in;
   logic          found_ff;
   logic [IW-1:0] best_ff;
   logic signed [7:0] bdp_ff;
   logic signed [5:0] bsp_ff;
   logic [IW-1:0] brk_ff;
   logic          ov_ff;
   logic [3:0]    oid_ff;
   logic          ohit_ff;
   logic [1:0]    ost_ff;

   logic          take, last, better, shrink;
   logic [IW-1:0] slot, drop_rk;
   logic signed [8:0] aged;

   assign slot    = cmd_ff.slot[IW-1:0];
   assign last    = (idx_ff == IW'(TASK_SLOTS - 1));
   assign q_ready = (st_ff == aptp_pkg::BK_IDLE) && !ov_ff;
   assign take    = q_valid && q_ready;
   assign better  = !found_ff || (dp_ff[idx_ff] < bdp_ff) ||
                    (dp_ff[idx_ff] == bdp_ff && (sp_ff[idx_ff] < bsp_ff ||
                     (sp_ff[idx_ff] == bsp_ff && rk_ff[idx_ff] < brk_ff)));
   assign aged    = 9'(dp_ff[idx_ff]) - 9'(aging_step);

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         aptp_pkg::BK_IDLE: if (take) st_in = aptp_pkg::BK_DONE;
         aptp_pkg::BK_DONE: if (cmd_ff.kind == aptp_pkg::REQ_PICK && cnt_ff != '0)
                               st_in = aptp_pkg::BK_SCAN;
                            else st_in = aptp_pkg::BK_IDLE;
         aptp_pkg::BK_SCAN: if (last) st_in = aptp_pkg::BK_AGE;
         aptp_pkg::BK_AGE:  if (last) st_in = aptp_pkg::BK_IDLE;
         default:           st_in = aptp_pkg::BK_IDLE;
      endcase
   end

   assign idx_in = (st_ff == aptp_pkg::BK_SCAN || st_ff == aptp_pkg::BK_AGE) ?
                   (last ? '0 : idx_ff + IW'(1)) : '0;

   // rank removal happens at the last scan cycle (pick) or at done (remove)
   always_comb begin
      shrink  = 1'b0;
      drop_rk = rk_ff[slot];
      rdy_in  = rdy_ff;
      if (st_ff == aptp_pkg::BK_DONE && cmd_ff.kind == aptp_pkg::REQ_REMOVE &&
          cmd_ff.slot_ok && rdy_ff[slot]) begin
         shrink = 1'b1;
         rdy_in[slot] = 1'b0;
      end else if (st_ff == aptp_pkg::BK_SCAN && last) begin
         shrink  = 1'b1;
         drop_rk = (better && rdy_ff[idx_ff]) ? rk_ff[idx_ff] : brk_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= aptp_pkg::BK_IDLE;
         ov_ff  <= 1'b0;
         rdy_ff <= '0;
         cnt_ff <= '0;
         idx_ff <= '0;
         found_ff <= 1'b0;
         for (int k = 0; k < TASK_SLOTS; k++) begin
            sp_ff[k] <= '0;
            dp_ff[k] <= '0;
            rk_ff[k] <= '0;
         end
      end else begin
         st_ff  <= st_in;
         idx_ff <= idx_in;
         if (ov_ff && out_ready) ov_ff <= 1'b0;
         if (take) begin
            cmd_ff   <= q_cmd;
            found_ff <= 1'b0;
         end
         if (shrink) begin
            for (int k = 0; k < TASK_SLOTS; k++)
               if (rdy_ff[k] && rk_ff[k] > drop_rk) rk_ff[k] <= rk_ff[k] - IW'(1);
         end
         if (st_ff == aptp_pkg::BK_DONE) begin
            oid_ff  <= '0;
            ohit_ff <= 1'b0;
            ost_ff  <= aptp_pkg::ST_DONE;
            unique case (cmd_ff.kind)
               aptp_pkg::REQ_PICK: begin
                  if (cnt_ff == '0) begin
                     ost_ff <= aptp_pkg::ST_EMPTY;
                     ov_ff  <= 1'b1;
                  end
               end
               aptp_pkg::REQ_INSERT: begin
                  ov_ff <= 1'b1;
                  if (!cmd_ff.slot_ok || rdy_ff[slot]) ost_ff <= aptp_pkg::ST_IGNORED;
                  else begin
                     rdy_ff[slot] <= 1'b1;
                     rk_ff[slot]  <= cnt_ff[IW-1:0];
                     cnt_ff       <= cnt_ff + CW'(1);
                  end
               end
               aptp_pkg::REQ_REMOVE: begin
                  ov_ff <= 1'b1;
                  if (!cmd_ff.slot_ok || !rdy_ff[slot]) ost_ff <= aptp_pkg::ST_IGNORED;
                  else begin
                     rdy_ff       <= rdy_in;
                     rk_ff[slot]  <= '0;
                     cnt_ff       <= cnt_ff - CW'(1);
                  end
               end
               aptp_pkg::REQ_SETPRI: begin
                  ov_ff <= 1'b1;
                  if (!cmd_ff.slot_ok || !cmd_ff.prio_ok) ost_ff <= aptp_pkg::ST_IGNORED;
                  else begin
                     sp_ff[slot] <= cmd_ff.prio;
                     dp_ff[slot] <= 8'(cmd_ff.prio);
                  end
               end
               default: ;
            endcase
         end
         if (st_ff == aptp_pkg::BK_SCAN && rdy_ff[idx_ff] && better) begin
            found_ff <= 1'b1;
            best_ff  <= idx_ff;
            bdp_ff   <= dp_ff[idx_ff];
            bsp_ff   <= sp_ff[idx_ff];
            brk_ff   <= rk_ff[idx_ff];
         end
         if (st_ff == aptp_pkg::BK_SCAN && last) begin
            rdy_ff[(rdy_ff[idx_ff] && better) ? idx_ff : best_ff] <= 1'b0;
            rk_ff[(rdy_ff[idx_ff] && better) ? idx_ff : best_ff]  <= '0;
            cnt_ff <= cnt_ff - CW'(1);
         end
         if (st_ff == aptp_pkg::BK_AGE) begin
            if (idx_ff == best_ff) dp_ff[idx_ff] <= 8'(sp_ff[idx_ff]);
            else if (rdy_ff[idx_ff])
               dp_ff[idx_ff] <= (aged < 9'(aptp_pkg::DYN_FLOOR)) ?
                                aptp_pkg::DYN_FLOOR : aged[7:0];
            if (last) begin
               ov_ff   <= 1'b1;
               oid_ff  <= 4'(best_ff);
               ohit_ff <= 1'b1;
               ost_ff  <= aptp_pkg::ST_DONE;
            end
         end
      end
   end

   assign out_valid  = ov_ff;
   assign out_id     = oid_ff;
   assign out_hit    = ohit_ff;
   assign out_status = ost_ff;
endmodule

[rtl/aptp_checker.sv]
`timescale 1ns / 1ps
module aptp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word dropped");
   a_hit_id: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[4] |-> rsp_tdata[3:0] == 4'd0)
      else $error("id without hit");
   a_hit_st: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |-> rsp_tdata[6:5] == 2'd0)
      else $error("hit with bad status");
   a_st: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[6:5] != 2'd3 && rsp_tdata[7] == 1'b0)
      else $error("bad status code");
endmodule

bind aging_priority_task_picker aptp_checker u_chk (
   .clock(clock), .reset(reset),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

[dv/aging_priority_task_picker_checker.sv]
`timescale 1ns / 1ps
module aging_priority_task_picker_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_wr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // req_type[1:0], task_id[5:2], new_prio[11:6]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // chosen_id[3:0], chosen_valid[4], status[6:5]
   output int          fail_count,
   output int          pending,
   output int          picks_done,
   output int          floor_hits
);
   localparam int SLOTS = 16;

   logic [2:0]        age_step;
   logic              is_ready [SLOTS];
   logic signed [5:0] base_prio [SLOTS];
   logic signed [7:0] aged_prio [SLOTS];
   logic [4:0]        rank [SLOTS];
   logic [4:0]        n_ready;
   logic [7:0]        expected_words [$];

   task automatic drop_from_queue(input int s);
      for (int k = 0; k < SLOTS; k++)
         if (is_ready[k] && k != s && rank[k] > rank[s])
            rank[k]--;
      is_ready[s] = 1'b0;
      rank[s] = '0;
      if (n_ready > 0)
         n_ready--;
   endtask

   task automatic schedule_word(input logic [15:0] w, output logic [7:0] res);
      aptp_pkg::req_kind_type kind;
      int                id;
      logic signed [5:0] prio;
      int                best;
      int                v;
      logic [3:0]        chosen;
      logic              found;
      aptp_pkg::status_type st;
      kind = aptp_pkg::req_kind_type'(w[1:0]);
      id = w[5:2];
      prio = w[11:6];
      best = -1;
      chosen = '0;
      found = 1'b0;
      st = aptp_pkg::ST_DONE;
      case (kind)
         aptp_pkg::REQ_PICK: begin
            for (int k = 0; k < SLOTS; k++) begin
               if (!is_ready[k]) continue;
               if (best < 0) best = k;
               else if (aged_prio[k] < aged_prio[best]) best = k;
               else if (aged_prio[k] == aged_prio[best] &&
                        (base_prio[k] < base_prio[best] ||
                         (base_prio[k] == base_prio[best] && rank[k] < rank[best])))
                  best = k;
            end
            if (best < 0) begin
               st = aptp_pkg::ST_EMPTY;
            end else begin
               drop_from_queue(best);
               aged_prio[best] = 8'(base_prio[best]);
               for (int k = 0; k < SLOTS; k++)
                  if (is_ready[k]) begin
                     v = int'(aged_prio[k]) - int'(age_step);
                     if (v <= int'(aptp_pkg::DYN_FLOOR)) begin
                        v = int'(aptp_pkg::DYN_FLOOR);
                        floor_hits++;
                     end
                     aged_prio[k] = v[7:0];
                  end
               chosen = best[3:0];
               found = 1'b1;
               picks_done++;
            end
         end
         aptp_pkg::REQ_INSERT: begin
            if (is_ready[id]) st = aptp_pkg::ST_IGNORED;
            else begin
               is_ready[id] = 1'b1;
               rank[id] = n_ready;
               n_ready++;
            end
         end
         aptp_pkg::REQ_REMOVE: begin
            if (!is_ready[id]) st = aptp_pkg::ST_IGNORED;
            else drop_from_queue(id);
         end
         default: begin
            if (prio > aptp_pkg::PRIO_MAX || prio < aptp_pkg::PRIO_MIN)
               st = aptp_pkg::ST_IGNORED;
            else begin
               base_prio[id] = prio;
               aged_prio[id] = 8'(prio);
            end
         end
      endcase
      res = {1'b0, st, found, chosen};
   endtask

   always @(posedge clock) begin
      logic [7:0] res;
      logic [7:0] exp_w;
      if (reset) begin
         age_step = 3'd1;
         for (int k = 0; k < SLOTS; k++) begin
            is_ready[k] = 1'b0;
            base_prio[k] = '0;
            aged_prio[k] = '0;
            rank[k] = '0;
         end
         n_ready = '0;
         expected_words.delete();
         fail_count = 0;
         picks_done = 0;
         floor_hits = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t unexpected result word %h", $time, rsp_tdata);
            end else begin
               exp_w = expected_words.pop_front();
               if (rsp_tdata[3:0] !== exp_w[3:0] || rsp_tdata[4] !== exp_w[4] ||
                   rsp_tdata[6:5] !== exp_w[6:5]) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t mismatch: id %0d/%0d valid %0b/%0b status %0d/%0d (exp/act)",
                        $time, exp_w[3:0], rsp_tdata[3:0], exp_w[4], rsp_tdata[4],
                        exp_w[6:5], rsp_tdata[6:5]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            schedule_word(req_tdata, res);
            expected_words.push_back(res);
         end
         if (csr_wr_en)
            age_step = csr_wr_data;
      end
      pending = expected_words.size();
   end

   final begin
      if (expected_words.size() != 0)
         $display("%0d result words never arrived", expected_words.size());
   end
endmodule

[dv/aging_priority_task_picker_tb.sv]
`timescale 1ns / 1ps
module aging_priority_task_picker_tb;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   int          fail_count, pending, picks_done, floor_hits;
   int          tx_idle_pct = 0, rx_idle_pct = 0, rx_hold = 0, words_sent = 0;
   logic        hold_start = 1'b0;
   logic        hold_done = 1'b0;

   always #10 clock = ~clock;

   aging_priority_task_picker dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   aging_priority_task_picker_checker chk (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending(pending),
      .picks_done(picks_done), .floor_hits(floor_hits)
   );

   // receiver: random stall, or a long counted hold-off
   always @(negedge clock) begin
      if (hold_start && !hold_done) begin
         rx_hold = 400;
         hold_done = 1'b1;
      end
      if (rx_hold > 0) begin
         rsp_tready = 1'b0;
         rx_hold--;
      end else begin
         rsp_tready = !reset && ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic send_word(input aptp_pkg::req_kind_type kind, input logic [3:0] id,
                            input logic [5:0] prio);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {4'b0, prio, id, kind};
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic settle_and_config(input logic [2:0] step);
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = step;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic random_words(input int count);
      int r;
      aptp_pkg::req_kind_type kind;
      logic [5:0] prio;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         kind = r < 35 ? aptp_pkg::REQ_INSERT : r < 60 ? aptp_pkg::REQ_PICK :
                r < 78 ? aptp_pkg::REQ_REMOVE : aptp_pkg::REQ_SETPRI;
         prio = ($urandom_range(99) < 80) ? 6'($signed($urandom_range(40)) - 20)
                                          : 6'($urandom_range(63));
         send_word(kind, 4'($urandom_range(15)), prio);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed
      send_word(aptp_pkg::REQ_PICK, 4'd0, 6'd0);
      send_word(aptp_pkg::REQ_REMOVE, 4'd3, 6'd0);
      send_word(aptp_pkg::REQ_SETPRI, 4'd0, 6'sd20);
      send_word(aptp_pkg::REQ_SETPRI, 4'd15, -6'sd20);
      send_word(aptp_pkg::REQ_SETPRI, 4'd1, 6'sd21);
      send_word(aptp_pkg::REQ_SETPRI, 4'd2, -6'sd21);
      send_word(aptp_pkg::REQ_SETPRI, 4'd3, 6'sd31);
      send_word(aptp_pkg::REQ_SETPRI, 4'd4, -6'sd32);
      send_word(aptp_pkg::REQ_SETPRI, 4'd5, 6'sd0);
      send_word(aptp_pkg::REQ_INSERT, 4'd0, 6'd0);
      send_word(aptp_pkg::REQ_INSERT, 4'd15, 6'd0);
      send_word(aptp_pkg::REQ_INSERT, 4'd5, 6'd0);
      send_word(aptp_pkg::REQ_INSERT, 4'd6, 6'd0);
      send_word(aptp_pkg::REQ_INSERT, 4'd0, 6'd0);
      send_word(aptp_pkg::REQ_PICK, 4'd0, 6'd0);
      send_word(aptp_pkg::REQ_REMOVE, 4'd6, 6'd0);
      send_word(aptp_pkg::REQ_REMOVE, 4'd6, 6'd0);
      send_word(aptp_pkg::REQ_SETPRI, 4'd0, 6'd0);
      send_word(aptp_pkg::REQ_PICK, 4'd0, 6'd0);
      send_word(aptp_pkg::REQ_PICK, 4'd0, 6'd0);
      send_word(aptp_pkg::REQ_PICK, 4'd0, 6'd0);

      tx_idle_pct = 17; rx_idle_pct = 63;
      settle_and_config(3'd0);
      random_words(200);
      settle_and_config(3'd7);
      random_words(250);

      tx_idle_pct = 63; rx_idle_pct = 17;
      settle_and_config(3'd3);
      random_words(250);

      tx_idle_pct = 0; rx_idle_pct = 0;
      settle_and_config(3'd7);
      hold_start = 1'b1;
      random_words(300);
      settle_and_config(3'd1);
      random_words(300);

      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("sent %0d request words, %0d successful picks, %0d aging floor hits",
         words_sent, picks_done, floor_hits);
      $display("aging steps 0/1/3/7 under sender, receiver and hold-off back-pressure");
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #50ms;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
